@@ rtl/core/skvt_pkg.sv @@
// Package for the string key/value table: sizes, request/response items,
// request and status codes, controller states and text helper functions.
// No dependencies.
package skvt_pkg;

    localparam int MAX_ENTRIES   = 64;
    localparam int KEY_CHARS     = 8;
    localparam int TEXT_CHARS    = 8;
    localparam int IDX_W         = $clog2(MAX_ENTRIES);
    localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W         = 64;
    localparam int INT_W         = 32;
    localparam int TEXT_W        = 64;
    localparam int ENTRY_INDEX_W = 6;
    localparam int LEN_W         = 4;
    localparam logic [7:0] TILDE_CHAR = 8'h7E;

    typedef enum logic [1:0] {
        REQ_EXACT  = 2'd0,
        REQ_PREFIX = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_REMOVE = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    typedef struct packed {
        req_kind_t                 req_type;
        logic [KEY_W-1:0]          query_key;
        logic signed [INT_W-1:0]   int_value;
        logic [TEXT_W-1:0]         text_value;
        logic                      has_text;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [ENTRY_INDEX_W-1:0]  entry_index;
        logic signed [INT_W-1:0]   found_int;
        logic [TEXT_W-1:0]         found_text;
    } rsp_t;

    // keep bytes up to the first zero byte or the char limit, rest zero
    function automatic logic [63:0] norm_text(logic [63:0] raw, int nchars);
        logic [63:0] v;
        logic        stop;
        v    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!stop && i < nchars && raw[8*i +: 8] != 8'd0) begin
                v[8*i +: 8] = raw[8*i +: 8];
            end
            else begin
                stop = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic logic [LEN_W-1:0] text_len(logic [63:0] raw, int nchars);
        logic [LEN_W-1:0] len;
        logic             stop;
        len  = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!stop && i < nchars && raw[8*i +: 8] != 8'd0) begin
                len = LEN_W'(i + 1);
            end
            else begin
                stop = 1'b1;
            end
        end
        return len;
    endfunction

    function automatic logic prefix_hit(logic [63:0] stored, logic [63:0] q,
                                        logic [LEN_W-1:0] qlen);
        logic       ok;
        logic [7:0] nxt;
        ok = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(qlen) && stored[8*i +: 8] != q[8*i +: 8]) begin
                ok = 1'b0;
            end
        end
        if (int'(qlen) < KEY_CHARS && int'(qlen) < 8) begin
            nxt = stored[8*qlen[2:0] +: 8];
        end
        else begin
            nxt = 8'd0;
        end
        return ok && (nxt == TILDE_CHAR || nxt == 8'd0);
    endfunction

endpackage

@@ rtl/core/string_key_value_table_unit.sv @@
// Top level of the string key/value table: entry memories, scan/shift sequencer
// and the shared key compare unit.
// Depends on skvt_pkg.
//
// Usage:
//   Request channel: drive req and raise start; the item is taken at a rising
//   edge with start high and busy low. busy stays high while a lookup or remove
//   is processed; an insert never raises it.
//   Result channel: done is high for one cycle with rsp valid; the receiver
//   must take it then, there is no back-pressure.
//   Sequencing: an insert raises done at the accepting edge. Lookup and remove
//   scan slots from 0 through one memory read port and one key comparator, one
//   slot per cycle, and a lookup ends at the first hit or after the last entry.
//   A remove hit then moves every later entry down, one per cycle, before done.
//   Throughput: one item at a time; the next start may be taken at the edge
//   that ends the done cycle. Inserts may follow one per cycle.
//   Reset: entry_count clears, the table is empty; entry memories are not
//   cleared and need no clearing pass.
module string_key_value_table_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  skvt_pkg::req_t req,
    output logic           done,
    output skvt_pkg::rsp_t rsp
);
    import skvt_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;

    req_kind_t            type_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [LEN_W-1:0]     qlen_reg;

    logic [KEY_W-1:0]     key_mem  [MAX_ENTRIES];
    logic [INT_W-1:0]     int_mem  [MAX_ENTRIES];
    logic [TEXT_W-1:0]    text_mem [MAX_ENTRIES];
    logic [KEY_W-1:0]     rd_key_reg;
    logic [INT_W-1:0]     rd_int_reg;
    logic [TEXT_W-1:0]    rd_text_reg;

    logic                 accept;
    logic [KEY_W-1:0]     in_key;
    logic [TEXT_W-1:0]    in_text;
    logic [IDX_W-1:0]     rd_addr;
    logic                 we_kv, we_text;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_W-1:0]     wr_key;
    logic [INT_W-1:0]     wr_int;
    logic [TEXT_W-1:0]    wr_text;
    logic                 key_match;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign in_key  = norm_text(req.query_key, KEY_CHARS);
    assign in_text = norm_text(req.text_value, TEXT_CHARS);
    assign rd_addr = ptr_reg[IDX_W-1:0];
    assign done    = done_reg;
    assign rsp     = rsp_reg;

    // shared compare unit
    always_comb
    begin
        if (type_reg == REQ_PREFIX) begin
            key_match = prefix_hit(rd_key_reg, key_reg, qlen_reg);
        end
        else begin
            key_match = (rd_key_reg == key_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_kv) begin
            key_mem[wr_addr] <= wr_key;
            int_mem[wr_addr] <= wr_int;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_int_reg <= int_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_text) begin
            text_mem[wr_addr] <= wr_text;
        end
        rd_text_reg <= text_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            type_reg <= req.req_type;
            key_reg  <= in_key;
            qlen_reg <= text_len(req.query_key, KEY_CHARS);
        end
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ptr_reg      <= '0;
            pend_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            pend_vld_reg <= pend_vld_next;
            done_reg     <= done_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        hit_idx_next  = hit_idx_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        we_kv         = 1'b0;
        we_text       = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        wr_key        = in_key;
        wr_int        = req.int_value;
        wr_text       = in_text;

        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    rsp_next = '0;
                    if (req.req_type == REQ_INSERT) begin
                        done_next = 1'b1;
                        if (int'(count_reg) >= MAX_ENTRIES - 1) begin
                            rsp_next.status = STAT_FULL;
                        end
                        else begin
                            we_kv                = 1'b1;
                            we_text              = req.has_text;
                            count_next           = count_reg + CNT_W'(1);
                            rsp_next.status      = STAT_OK;
                            rsp_next.entry_index = ENTRY_INDEX_W'(count_reg);
                        end
                    end
                    else begin
                        state_next    = S_SCAN;
                        ptr_next      = '0;
                        pend_vld_next = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                if (pend_vld_reg && key_match) begin
                    pend_vld_next = 1'b0;
                    if (type_reg == REQ_REMOVE) begin
                        state_next   = S_SHIFT;
                        hit_idx_next = pend_idx_reg;
                        ptr_next     = CNT_W'(pend_idx_reg) + CNT_W'(1);
                    end
                    else begin
                        state_next           = S_IDLE;
                        done_next            = 1'b1;
                        rsp_next.status      = STAT_OK;
                        rsp_next.entry_index = ENTRY_INDEX_W'(pend_idx_reg);
                        rsp_next.found_int   = rd_int_reg;
                        rsp_next.found_text  = rd_text_reg;
                    end
                end
                else if (ptr_reg < count_reg) begin
                    ptr_next      = ptr_reg + CNT_W'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = ptr_reg[IDX_W-1:0];
                end
                else begin
                    state_next      = S_IDLE;
                    pend_vld_next   = 1'b0;
                    done_next       = 1'b1;
                    rsp_next.status = STAT_NOT_FOUND;
                end
            end

            S_SHIFT:
            begin
                if (pend_vld_reg) begin
                    we_kv   = 1'b1;
                    we_text = 1'b1;
                    wr_addr = pend_idx_reg - IDX_W'(1);
                    wr_key  = rd_key_reg;
                    wr_int  = rd_int_reg;
                    wr_text = rd_text_reg;
                end
                if (ptr_reg < count_reg) begin
                    ptr_next      = ptr_reg + CNT_W'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = ptr_reg[IDX_W-1:0];
                end
                else begin
                    state_next           = S_IDLE;
                    pend_vld_next        = 1'b0;
                    count_next           = count_reg - CNT_W'(1);
                    done_next            = 1'b1;
                    rsp_next.status      = STAT_OK;
                    rsp_next.entry_index = ENTRY_INDEX_W'(hit_idx_reg);
                end
            end

            default:
            begin
                state_next    = S_IDLE;
                pend_vld_next = 1'b0;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_ENTRIES - 1)
        else $error("entry count above table capacity");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != S_IDLE || accept))
        else $error("result without an item in progress");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != STAT_OK |-> rsp.entry_index == '0 &&
            rsp.found_int == '0 && rsp.found_text == '0)
        else $error("failed item carries payload");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_INSERT && int'(count_reg) < MAX_ENTRIES - 1
        |=> count_reg == $past(count_reg) + CNT_W'(1) && done)
        else $error("insert did not append");

endmodule

@@ sim/string_key_value_table_unit_tb.sv @@
// Testbench for string_key_value_table_unit: directed, fill/drain and random
// request items checked against an in-bench table predictor.
// Depends on skvt_pkg and the string_key_value_table_unit RTL.
`timescale 1ns / 1ps

module string_key_value_table_unit_tb;
    import skvt_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int SETTLE       = 2 * MAX_ENTRIES + 8;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // predicted table contents
    int                 tbl_count;
    logic [KEY_W-1:0]   tbl_key     [MAX_ENTRIES];
    logic [INT_W-1:0]   tbl_int     [MAX_ENTRIES];
    logic [TEXT_W-1:0]  tbl_text    [MAX_ENTRIES];
    bit                 tbl_text_ok [MAX_ENTRIES];

    rsp_t expected_rsp [$];
    rsp_t want_rsp;

    int mismatches;
    int n_results;
    int n_hits;
    int n_full;
    int n_sent [4];

    string_key_value_table_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    function automatic int text_chars(logic [63:0] raw, int lim);
        int n;
        n = 0;
        while (n < lim && raw[8*n +: 8] != 8'h00)
            n++;
        return n;
    endfunction

    function automatic logic [63:0] clip_to(logic [63:0] raw, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v[8*i +: 8] = raw[8*i +: 8];
        return v;
    endfunction

    function automatic bit key_starts(logic [63:0] stored, logic [63:0] q, int qlen);
        logic [7:0] after_q;
        if (clip_to(stored, qlen) != clip_to(q, qlen))
            return 1'b0;
        after_q = (qlen < KEY_CHARS) ? stored[8*qlen +: 8] : 8'h00;
        return after_q == TILDE_CHAR || after_q == 8'h00;
    endfunction

    // applies one request to the predicted table and returns its answer
    function automatic rsp_t predict_table_op(req_t r);
        rsp_t        o;
        logic [63:0] k;
        logic [63:0] t;
        int          klen;
        int          hit;
        o        = '0;
        o.status = STAT_NOT_FOUND;
        klen     = text_chars(r.query_key, KEY_CHARS);
        k        = clip_to(r.query_key, klen);
        t        = clip_to(r.text_value, text_chars(r.text_value, TEXT_CHARS));
        hit      = -1;
        case (r.req_type)
            REQ_EXACT, REQ_PREFIX:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (hit < 0 && ((r.req_type == REQ_EXACT) ? (tbl_key[i] == k)
                                    : key_starts(tbl_key[i], k, klen)))
                        hit = i;
                end
                if (hit >= 0)
                begin
                    o.status      = STAT_OK;
                    o.entry_index = ENTRY_INDEX_W'(hit);
                    o.found_int   = tbl_int[hit];
                    o.found_text  = tbl_text[hit];
                    n_hits++;
                end
            end
            REQ_INSERT:
            begin
                if (tbl_count + 1 >= MAX_ENTRIES)
                begin
                    o.status = STAT_FULL;
                    n_full++;
                end
                else
                begin
                    tbl_key[tbl_count] = k;
                    tbl_int[tbl_count] = r.int_value;
                    if (r.has_text)
                    begin
                        tbl_text[tbl_count]    = t;
                        tbl_text_ok[tbl_count] = 1'b1;
                    end
                    o.status      = STAT_OK;
                    o.entry_index = ENTRY_INDEX_W'(tbl_count);
                    tbl_count++;
                end
            end
            default:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (hit < 0 && tbl_key[i] == k)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    for (int j = hit; j + 1 < tbl_count; j++)
                    begin
                        tbl_key[j]     = tbl_key[j+1];
                        tbl_int[j]     = tbl_int[j+1];
                        tbl_text[j]    = tbl_text[j+1];
                        tbl_text_ok[j] = tbl_text_ok[j+1];
                    end
                    tbl_count--;
                    o.status      = STAT_OK;
                    o.entry_index = ENTRY_INDEX_W'(hit);
                end
            end
        endcase
        return o;
    endfunction

    function automatic logic [63:0] str8(string s);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    function automatic req_t make_item(req_kind_t kind, logic [63:0] key,
                                       logic [31:0] ival, logic [63:0] txt, logic ht);
        req_t it;
        it.req_type   = kind;
        it.query_key  = key;
        it.int_value  = ival;
        it.text_value = txt;
        it.has_text   = ht;
        return it;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 5))
            0, 3:    return "a";
            1, 4:    return "b";
            2:       return TILDE_CHAR;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // random bytes behind the terminating zero, which the block must ignore
    function automatic logic [63:0] with_garbage(logic [63:0] v, int len);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        if (len < 7 && $urandom_range(0, 2) == 0)
        begin
            for (int i = len + 1; i < 8; i++)
                v[8*i +: 8] = junk[8*i +: 8];
        end
        return v;
    endfunction

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        int          len;
        k = '0;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
            k[8*i +: 8] = pick_char();
        return with_garbage(k, len);
    endfunction

    // no text may be omitted into a slot whose text was never written
    function automatic logic pick_has_text();
        return tbl_text_ok[tbl_count] ? 1'($urandom_range(0, 1)) : 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ERROR %s: got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(req_t it);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req   <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        expected_rsp.push_back(predict_table_op(it));
        n_sent[int'(it.req_type)]++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            n_results++;
            if (expected_rsp.size() == 0)
                report_mismatch("result with none pending", 64'(rsp.status), '0);
            else
            begin
                want_rsp = expected_rsp.pop_front();
                if (rsp.status !== want_rsp.status)
                    report_mismatch("status", 64'(rsp.status), 64'(want_rsp.status));
                if (rsp.entry_index !== want_rsp.entry_index)
                    report_mismatch("entry_index", 64'(rsp.entry_index),
                                    64'(want_rsp.entry_index));
                if (rsp.found_int !== want_rsp.found_int)
                    report_mismatch("found_int", 64'(rsp.found_int), 64'(want_rsp.found_int));
                if (rsp.found_text !== want_rsp.found_text)
                    report_mismatch("found_text", rsp.found_text, want_rsp.found_text);
            end
        end
    end

    task automatic test_directed_cases();
        send_item(make_item(REQ_EXACT,  str8(""), 0, 0, 1'b0));
        send_item(make_item(REQ_PREFIX, str8(""), 0, 0, 1'b0));
        send_item(make_item(REQ_REMOVE, str8("a"), 0, 0, 1'b0));
        send_item(make_item(REQ_INSERT, str8(""), 32'h8000_0000, '1, 1'b1));
        send_item(make_item(REQ_INSERT, str8("ab~cd"), 32'h7FFF_FFFF,
                            64'h1234_5678_9A00_6968, 1'b1));
        send_item(make_item(REQ_INSERT, '1, 32'hFFFF_FFFF, 0, 1'b1));
        send_item(make_item(REQ_INSERT, 64'hDEAD_BEEF_0000_6261, 0, str8("x"), 1'b1));
        send_item(make_item(REQ_INSERT, str8("ab"), 5, str8("dup"), 1'b1));
        send_item(make_item(REQ_EXACT,  64'h0102_0304_0500_6261, 0, 0, 1'b0));
        send_item(make_item(REQ_PREFIX, str8("ab"), 0, 0, 1'b0));
        send_item(make_item(REQ_PREFIX, str8(""), 0, 0, 1'b0));
        send_item(make_item(REQ_PREFIX, '1, 0, 0, 1'b0));
        send_item(make_item(REQ_PREFIX, str8("a"), 0, 0, 1'b0));
        send_item(make_item(REQ_EXACT,  '1, 0, 0, 1'b0));
        send_item(make_item(REQ_REMOVE, str8(""), 0, 0, 1'b0));
        send_item(make_item(REQ_INSERT, str8("~z"), 7, str8("tilde"), 1'b1));
        send_item(make_item(REQ_PREFIX, str8(""), 0, 0, 1'b0));
        send_item(make_item(REQ_REMOVE, str8("ab"), 0, 0, 1'b0));
        send_item(make_item(REQ_REMOVE, str8("~z"), 0, 0, 1'b0));
        // slot keeps the text left behind by the removed entry
        send_item(make_item(REQ_INSERT, str8("q"), 9, '1, 1'b0));
        send_item(make_item(REQ_EXACT,  str8("q"), 0, 0, 1'b0));
        send_item(make_item(REQ_REMOVE, str8("nothere"), 0, 0, 1'b0));
        send_item(make_item(REQ_EXACT,  {$urandom, $urandom} | 64'h8080_8080_8080_8080,
                            0, 0, 1'b0));
    endtask

    task automatic test_fill_and_drain();
        while (tbl_count + 1 < MAX_ENTRIES)
            send_item(make_item(REQ_INSERT, {48'd0, 8'(tbl_count + 1), 8'h4B}, $urandom,
                                {$urandom, $urandom}, pick_has_text()));
        repeat (2)
            send_item(make_item(REQ_INSERT, rand_key(), $urandom, {$urandom, $urandom},
                                1'b1));
        send_item(make_item(REQ_EXACT,  tbl_key[MAX_ENTRIES-2], 0, 0, 1'b0));
        send_item(make_item(REQ_PREFIX, tbl_key[MAX_ENTRIES-2], 0, 0, 1'b0));
        send_item(make_item(REQ_PREFIX, str8("K"), 0, 0, 1'b0));
        // front removals force the longest shifts
        while (tbl_count > 0)
            send_item(make_item(REQ_REMOVE, tbl_key[0], 0, 0, 1'b0));
    endtask

    task automatic test_random_mix(int n_items);
        req_kind_t   kind;
        logic [63:0] k;
        int          ins_w;
        int          roll;
        int          slot;
        int          len;
        for (int n = 0; n < n_items; n++)
        begin
            ins_w = (tbl_count > 48) ? 15 : ((tbl_count < 6) ? 55 : 35);
            roll  = $urandom_range(0, 99);
            if (roll < ins_w)
                kind = REQ_INSERT;
            else if (roll < ins_w + 25)
                kind = REQ_REMOVE;
            else if (roll < ins_w + 25 + (75 - ins_w) / 2)
                kind = REQ_EXACT;
            else
                kind = REQ_PREFIX;

            k = rand_key();
            if (kind != REQ_INSERT && tbl_count > 0 && $urandom_range(0, 3) != 0)
            begin
                slot = $urandom_range(0, tbl_count - 1);
                len  = text_chars(tbl_key[slot], KEY_CHARS);
                if (kind == REQ_PREFIX)
                    len = $urandom_range(0, len);
                k = with_garbage(clip_to(tbl_key[slot], len), len);
            end

            send_item(make_item(kind, k, $urandom,
                                ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : rand_key(),
                                (kind == REQ_INSERT) ? pick_has_text()
                                                     : 1'($urandom_range(0, 1))));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fill_and_drain();
        test_random_mix(RANDOM_ITEMS);
        start <= 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d items: exact %0d, prefix %0d, insert %0d, remove %0d",
                 n_sent[0] + n_sent[1] + n_sent[2] + n_sent[3],
                 n_sent[0], n_sent[1], n_sent[2], n_sent[3]);
        $display("Results checked %0d, lookup hits %0d, refused inserts %0d, mismatches %0d",
                 n_results, n_hits, n_full, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results pending", cycles, expected_rsp.size());
        $display("Verification failed");
        $finish;
    end

endmodule
